FILE: hw/rtl/nearest_occupied_cell_search_assert.svh
// assertion macros shared by the nearest occupied cell search rtl
`ifndef NEAREST_OCCUPIED_CELL_SEARCH_ASSERT_SVH
`define NEAREST_OCCUPIED_CELL_SEARCH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define NOCS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nocs: assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define NOCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nocs: assertion failed");

`endif

FILE: hw/rtl/nocs_pkg.sv
// shared constants, codes and structs of the nearest occupied cell search
`default_nettype none

package nocs_pkg;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam int CELLS  = GRID_W * GRID_H;
  localparam int X_W    = $clog2(GRID_W);
  localparam int Y_W    = $clog2(GRID_H);
  localparam int ADDR_W = $clog2(CELLS);

  localparam int CRD_W  = 9;
  localparam int DIFF_W = 11;
  localparam int MAG_W  = 10;
  localparam int SQ_W   = 20;
  localparam int DIST_W = 21;
  localparam int EV_W   = 16;
  localparam int ENT_W  = 17;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_QUERY = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef struct packed {
    logic             start;
    logic             vld;
    logic             last;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [CRD_W-1:0] qcol;
    logic [CRD_W-1:0] qrow;
  } scan_tap_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [EV_W-1:0] ev;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nocs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module nocs_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/nocs_best.sv
// squared distance pipeline and running best tracker for the grid scan
`default_nettype none

module nocs_best (
  input  logic                     clk,
  input  logic                     rst_n,
  input  nocs_pkg::scan_tap_t      tap,
  input  logic [nocs_pkg::ENT_W-1:0] rd_data,
  output nocs_pkg::scan_res_t      res
);
  import nocs_pkg::*;

  logic               vld_b_r;
  logic               last_b_r;
  logic [X_W-1:0]     x_b_r;
  logic [Y_W-1:0]     y_b_r;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [MAG_W-1:0]   mag_x;
  logic [MAG_W-1:0]   mag_y;
  logic [SQ_W-1:0]    sq_x;
  logic [SQ_W-1:0]    sq_y;

  logic               occ_c_r;
  logic               last_c_r;
  logic [EV_W-1:0]    ev_c_r;
  logic [SQ_W-1:0]    sqx_c_r;
  logic [SQ_W-1:0]    sqy_c_r;
  logic [DIST_W-1:0]  dist_sum;

  logic               have_r;
  logic [DIST_W-1:0]  best_r;
  logic [EV_W-1:0]    best_ev_r;
  logic               done_r;

  // stage b: read data lines up with the registered coordinates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r  <= 1'b0;
      last_b_r <= 1'b0;
    end else begin
      vld_b_r  <= tap.vld;
      last_b_r <= tap.last;
    end
    x_b_r <= tap.x;
    y_b_r <= tap.y;
  end

  assign dx    = DIFF_W'({1'b0, x_b_r}) - DIFF_W'(signed'(tap.qcol));
  assign dy    = DIFF_W'({1'b0, y_b_r}) - DIFF_W'(signed'(tap.qrow));
  assign mag_x = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign mag_y = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
  assign sq_x  = mag_x * mag_x;
  assign sq_y  = mag_y * mag_y;

  // stage c: squares registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_c_r  <= 1'b0;
      last_c_r <= 1'b0;
    end else begin
      occ_c_r  <= vld_b_r && rd_data[ENT_W-1];
      last_c_r <= last_b_r;
    end
    ev_c_r  <= rd_data[EV_W-1:0];
    sqx_c_r <= sq_x;
    sqy_c_r <= sq_y;
  end

  assign dist_sum = DIST_W'(sqx_c_r) + DIST_W'(sqy_c_r);

  // strict less-than keeps the first cell in raster order on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r    <= 1'b0;
      best_ev_r <= '0;
      done_r    <= 1'b0;
    end else begin
      done_r <= last_c_r;
      if (tap.start) begin
        have_r    <= 1'b0;
        best_ev_r <= '0;
      end else if (occ_c_r && (!have_r || (dist_sum < best_r))) begin
        have_r    <= 1'b1;
        best_ev_r <= ev_c_r;
      end
    end
    if (occ_c_r && (!have_r || (dist_sum < best_r))) begin
      best_r <= dist_sum;
    end
  end

  assign res.done  = done_r;
  assign res.found = have_r;
  assign res.ev    = best_ev_r;

endmodule

`default_nettype wire

FILE: hw/rtl/nearest_occupied_cell_search.sv
// top level of the nearest occupied cell search
`default_nettype none
`include "nearest_occupied_cell_search_assert.svh"

// Keeps a GRID_W x GRID_H grid of cells (64 x 64 here), each empty or holding a
// 16-bit event index, in one ram with registered reads. tuser selects the
// operation: write one cell (out-of-grid writes are dropped, a negative
// event_id empties the cell), clear the grid (one ram word per cycle), or query
// a point, which scans every cell in raster order through the ram read port,
// one cell per cycle, and returns the event of the occupied cell at the least
// squared distance, the first in raster order on a tie. Only a query produces
// an output transfer. After reset the block runs the same clearing pass with
// in_tready low. Writes and clears are accepted while a finished result still
// waits on the output.
module nearest_occupied_cell_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // col[8:0], row[17:9], event_id[34:18], zero fill
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // nearest_event[15:0]
  output logic [0:0]  out_tuser   // found[0]
);
  import nocs_pkg::*;

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [X_W-1:0]     x_r, x_nxt;
  logic [Y_W-1:0]     y_r, y_nxt;
  logic [CRD_W-1:0]   qcol_r, qcol_nxt;
  logic [CRD_W-1:0]   qrow_r, qrow_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [EV_W-1:0]    out_ev_r, out_ev_nxt;
  logic               out_found_r, out_found_nxt;

  func_t              f_func;
  logic [CRD_W-1:0]   f_col;
  logic [CRD_W-1:0]   f_row;
  logic [ENT_W-1:0]   f_ev;
  logic               acc;
  logic               col_ok;
  logic               row_ok;
  logic [2*(CRD_W+1)-1:0] wr_prod;
  logic               last_addr;
  logic               out_free;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic [ENT_W-1:0]   ram_rdata;

  scan_tap_t          tap;
  scan_res_t          res;

  assign f_func = func_t'(in_tuser);
  assign f_col  = in_tdata[8:0];
  assign f_row  = in_tdata[17:9];
  assign f_ev   = in_tdata[34:18];

  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;

  assign col_ok  = !f_col[CRD_W-1] && ({1'b0, f_col} < (CRD_W+1)'(GRID_W));
  assign row_ok  = !f_row[CRD_W-1] && ({1'b0, f_row} < (CRD_W+1)'(GRID_H));
  assign wr_prod = {1'b0, f_row} * (CRD_W+1)'(GRID_W);

  assign last_addr = (addr_r == ADDR_W'(CELLS - 1));
  assign out_free  = !out_vld_r || out_tready;

  // ram write port: clearing sweep or a single cell write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    if (state_r == ST_CLR) begin
      ram_we = 1'b1;
    end else if (acc && (f_func == FN_WRITE) && col_ok && row_ok) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(wr_prod) + ADDR_W'(f_col);
      ram_wdata = f_ev[ENT_W-1] ? '0 : {1'b1, f_ev[EV_W-1:0]};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    qcol_nxt      = qcol_r;
    qrow_nxt      = qrow_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_ev_nxt    = out_ev_r;
    out_found_nxt = out_found_r;
    unique case (state_r)
      ST_CLR: begin
        addr_nxt = addr_r + 1'b1;
        if (last_addr) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc && (f_func == FN_QUERY)) begin
          addr_nxt  = '0;
          x_nxt     = '0;
          y_nxt     = '0;
          qcol_nxt  = f_col;
          qrow_nxt  = f_row;
          state_nxt = ST_SCAN;
        end else if (acc && (f_func == FN_CLEAR)) begin
          addr_nxt  = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + 1'b1;
        if (x_r == X_W'(GRID_W - 1)) begin
          x_nxt = '0;
          y_nxt = y_r + 1'b1;
        end else begin
          x_nxt = x_r + 1'b1;
        end
        if (last_addr) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (res.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_ev_nxt    = res.ev;
          out_found_nxt = res.found;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
        addr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      addr_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      out_vld_r <= out_vld_nxt;
    end
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    qcol_r      <= qcol_nxt;
    qrow_r      <= qrow_nxt;
    out_ev_r    <= out_ev_nxt;
    out_found_r <= out_found_nxt;
  end

  assign tap.start = acc && (f_func == FN_QUERY);
  assign tap.vld   = (state_r == ST_SCAN);
  assign tap.last  = (state_r == ST_SCAN) && last_addr;
  assign tap.x     = x_r;
  assign tap.y     = y_r;
  assign tap.qcol  = qcol_r;
  assign tap.qrow  = qrow_r;

  nocs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  nocs_best u_best (
    .clk     (clk),
    .rst_n   (rst_n),
    .tap     (tap),
    .rd_data (ram_rdata),
    .res     (res)
  );

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_ev_r;
  assign out_tuser[0] = out_found_r;

  `NOCS_ASSERT_SAME(a_no_write_in_scan, ram_we, (state_r == ST_CLR) || (state_r == ST_IDLE))
  `NOCS_ASSERT_SAME(a_done_in_wait, res.done, state_r == ST_WAIT)
  `NOCS_ASSERT_NEXT(a_query_starts, tap.start, (state_r == ST_SCAN) && (addr_r == '0))
  `NOCS_ASSERT_SAME(a_empty_is_zero, out_tvalid && !out_tuser[0], out_tdata == '0)

endmodule

`default_nettype wire
